// File: rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// Lens position servo package
// Shared types, codes and constants for the lens position servo.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int unsigned SPEED_W  = 7;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned TOL_W    = 8;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned PROD_W   = 14;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SPEED_W-1:0] SPEED_MAX_RESET   = 7'd80;
    localparam logic [SPEED_W-1:0] SPEED_MIN_RESET   = 7'd35;
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET   = 8'd2;
    localparam logic [POS_W-1:0]   HOME_TARGET_RESET = 16'd300;

    localparam logic [POS_W-1:0] NEAR_LIMIT = 16'd20;
    localparam logic [POS_W-1:0] RAMP_LIMIT = 16'd100;

    // Division by 100 as a multiply by 5243 / 2^19, exact for products below 2^14.
    localparam int unsigned RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_TARGET = 3'd1,
        FUNC_HOME   = 3'd2,
        FUNC_ENC_REV = 3'd3,
        FUNC_ENC_FWD = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_DRIVE = 2'd1,
        CMD_STOP  = 2'd2
    } motor_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_MAX   = 2'd0,
        CFG_SPEED_MIN   = 2'd1,
        CFG_TOLERANCE   = 2'd2,
        CFG_HOME_TARGET = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        motor_cmd_t         cmd;
        logic [SPEED_W-1:0] base;
        logic               ramp;
        logic               ramp_up;
        logic               neg;
        logic [PROD_W-1:0]  prod;
        logic [POS_W-1:0]   position;
        logic               running;
    } drive_t;

endpackage

// File: rtl/core/lens_position_servo.sv
// Path: an input transfer passes through the input register, the state update
// stage and the result register before its result transfer.
// Throughput: one item per cycle while the result side is ready; the state update stage holds the loop on position.
// Reset: synchronous active-low aresetn clears the pipeline valids, sets homing
// mode, zero position and target, and loads the register defaults.
// ----------------------------------------------------------------------------
// Lens position servo
// Event-driven motor position servo with homing and a distance-based speed ramp.
// ----------------------------------------------------------------------------
module lens_position_servo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // target[15:0], step_count[23:16], zero fill
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // speed[7:0], position[23:8], running[24], zero fill
    output logic [1:0]  m_tuser    // motor_cmd[1:0]
);
    import lps_pkg::*;

    logic [SPEED_W-1:0] speed_max_reg;
    logic [SPEED_W-1:0] speed_min_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [POS_W-1:0]   home_target_reg;

    logic               in_valid_reg;
    logic [2:0]         in_func_reg;
    logic [POS_W-1:0]   in_target_reg;
    logic [STEP_W-1:0]  in_step_reg;

    logic               run_mode_reg,  run_mode_next;
    logic [POS_W-1:0]   lens_pos_reg,  lens_pos_next;
    logic [POS_W-1:0]   want_pos_reg,  want_pos_next;

    logic               st1_valid_reg;
    drive_t             st1_reg, st1_next;

    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic [1:0]         m_user_reg;

    logic               out_ready, st1_ready, in_ready;
    logic signed [16:0] pos_diff;
    logic [POS_W-1:0]   mag;
    logic [SPEED_W-1:0] ramp_diff;
    logic signed [7:0]  speed_fin;

    assign cfg_ready = 1'b1;
    assign out_ready = !m_valid_reg || m_tready;
    assign st1_ready = !st1_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || st1_ready;
    assign s_tready  = in_ready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_max_reg   <= SPEED_MAX_RESET;
            speed_min_reg   <= SPEED_MIN_RESET;
            tolerance_reg   <= TOLERANCE_RESET;
            home_target_reg <= HOME_TARGET_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPEED_MAX:   speed_max_reg   <= cfg_data[SPEED_W-1:0];
                CFG_SPEED_MIN:   speed_min_reg   <= cfg_data[SPEED_W-1:0];
                CFG_TOLERANCE:   tolerance_reg   <= cfg_data[TOL_W-1:0];
                CFG_HOME_TARGET: home_target_reg <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_ready && s_tvalid) begin
            in_func_reg   <= s_tuser;
            in_target_reg <= s_tdata[15:0];
            in_step_reg   <= s_tdata[23:16];
        end
    end

    always_comb begin
        run_mode_next = run_mode_reg;
        lens_pos_next = lens_pos_reg;
        want_pos_next = want_pos_reg;
        pos_diff  = {lens_pos_reg[POS_W-1], lens_pos_reg}
                  - {want_pos_reg[POS_W-1], want_pos_reg};
        mag       = pos_diff[16] ? POS_W'(-pos_diff) : pos_diff[POS_W-1:0];
        ramp_diff = (speed_max_reg >= speed_min_reg) ? speed_max_reg - speed_min_reg
                                                     : speed_min_reg - speed_max_reg;
        st1_next          = '0;
        st1_next.cmd      = CMD_NONE;
        st1_next.ramp_up  = speed_max_reg >= speed_min_reg;
        st1_next.prod     = PROD_W'(mag[6:0]) * PROD_W'(ramp_diff);

        case (func_t'(in_func_reg))
            FUNC_TICK: begin
                st1_next.cmd = CMD_DRIVE;
                if (!run_mode_reg) begin
                    st1_next.base = speed_max_reg;
                end else if (mag == '0) begin
                    st1_next.cmd = CMD_STOP;
                end else begin
                    st1_next.neg = pos_diff[16];
                    if (mag <= POS_W'(tolerance_reg)) begin
                        st1_next.base = '0;
                    end else if (mag <= NEAR_LIMIT) begin
                        st1_next.base = speed_min_reg;
                    end else if (mag > RAMP_LIMIT) begin
                        st1_next.base = speed_max_reg;
                    end else begin
                        st1_next.base = speed_min_reg;
                        st1_next.ramp = 1'b1;
                    end
                end
            end
            FUNC_TARGET: want_pos_next = in_target_reg;
            FUNC_HOME: begin
                st1_next.cmd = CMD_STOP;
                if (!run_mode_reg) begin
                    run_mode_next = 1'b1;
                    want_pos_next = home_target_reg;
                end else begin
                    lens_pos_next = '0;
                end
            end
            FUNC_ENC_REV: if (run_mode_reg) lens_pos_next = lens_pos_reg + POS_W'(in_step_reg);
            FUNC_ENC_FWD: if (run_mode_reg) lens_pos_next = lens_pos_reg - POS_W'(in_step_reg);
            default: ;
        endcase

        st1_next.position = lens_pos_next;
        st1_next.running  = run_mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            run_mode_reg  <= 1'b0;
            lens_pos_reg  <= '0;
            want_pos_reg  <= '0;
        end else if (st1_ready) begin
            st1_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                run_mode_reg <= run_mode_next;
                lens_pos_reg <= lens_pos_next;
                want_pos_reg <= want_pos_next;
            end
        end
        if (st1_ready && in_valid_reg) begin
            st1_reg <= st1_next;
        end
    end

    lps_speed_fin u_speed_fin (
        .drive (st1_reg),
        .speed (speed_fin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= st1_valid_reg;
        end
        if (out_ready && st1_valid_reg) begin
            m_data_reg <= {7'd0, st1_reg.running, st1_reg.position, speed_fin};
            m_user_reg <= st1_reg.cmd;
        end
    end

`ifndef SYNTHESIS
    a_mode_never_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(run_mode_reg))
        else $error("running mode left without reset");

    a_speed_zero_unless_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg != CMD_DRIVE) |-> (m_data_reg[7:0] == 8'd0))
        else $error("nonzero speed without a drive command");

    a_cmd_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_user_reg == CMD_NONE || m_user_reg == CMD_DRIVE
                         || m_user_reg == CMD_STOP))
        else $error("illegal motor command code");

    a_pos_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st1_ready && in_valid_reg) |=> $stable(lens_pos_reg))
        else $error("position changed without an item");
`endif

endmodule

// File: rtl/core/lps_speed_fin.sv
// ----------------------------------------------------------------------------
// Lens position servo speed finish
// Scales the ramp product by 1/100, applies the ramp offset and the sign.
// ----------------------------------------------------------------------------
module lps_speed_fin (
    input  lps_pkg::drive_t     drive,
    output logic signed [7:0]   speed
);
    import lps_pkg::*;

    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [SPEED_W-1:0]        quot;
    logic [SPEED_W-1:0]        mag;

    always_comb begin
        scaled = PROD_W'(drive.prod) * RECIP_MUL;
        quot   = scaled[RECIP_SHIFT +: SPEED_W];
        if (drive.ramp) begin
            mag = drive.ramp_up ? drive.base + quot : drive.base - quot;
        end else begin
            mag = drive.base;
        end
        speed = drive.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

// File: dv/tb_lens_position_servo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lens position servo testbench
// Drives event transfers and register writes into the servo, predicts each
// result from its own copy of the mode, position, target and registers, and
// compares every result transfer field by field. Both sides idle at random,
// and the result side holds off once for a long stretch to stall the input.
// ----------------------------------------------------------------------------
module tb_lens_position_servo;
    import lps_pkg::*;

    class lens_servo_predictor;

        typedef struct {
            motor_cmd_t  cmd;
            logic [7:0]  speed;
            logic [15:0] position;
            logic        running;
        } servo_result_t;

        logic [SPEED_W-1:0] speed_max;
        logic [SPEED_W-1:0] speed_min;
        logic [TOL_W-1:0]   tolerance;
        logic [POS_W-1:0]   home_target;
        logic               run_mode;
        logic [POS_W-1:0]   lens_position;
        logic [POS_W-1:0]   wanted_position;
        servo_result_t      pending_results[$];
        int                 errors;

        function new();
            speed_max       = SPEED_MAX_RESET;
            speed_min       = SPEED_MIN_RESET;
            tolerance       = TOLERANCE_RESET;
            home_target     = HOME_TARGET_RESET;
            run_mode        = 1'b0;
            lens_position   = '0;
            wanted_position = '0;
            errors          = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEED_MAX:   speed_max   = data[SPEED_W-1:0];
                CFG_SPEED_MIN:   speed_min   = data[SPEED_W-1:0];
                CFG_TOLERANCE:   tolerance   = data[TOL_W-1:0];
                CFG_HOME_TARGET: home_target = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        function int drive_speed(int mag);
            int lo;
            int hi;
            lo = speed_min;
            hi = speed_max;
            if (mag <= int'(tolerance)) return 0;
            if (mag <= int'(NEAR_LIMIT)) return lo;
            if (mag > int'(RAMP_LIMIT)) return hi;
            if (hi >= lo) return lo + (mag * (hi - lo)) / int'(RAMP_LIMIT);
            return lo - (mag * (lo - hi)) / int'(RAMP_LIMIT);
        endfunction

        function void accept_event(logic [2:0] func, logic [15:0] tgt, logic [7:0] steps);
            servo_result_t res;
            int pos_diff;
            int spd;
            res.cmd   = CMD_NONE;
            res.speed = '0;
            case (func)
                FUNC_TICK: begin
                    if (!run_mode) begin
                        res.cmd   = CMD_DRIVE;
                        res.speed = 8'(speed_max);
                    end else begin
                        pos_diff = int'($signed(lens_position))
                                 - int'($signed(wanted_position));
                        if (pos_diff == 0) begin
                            res.cmd = CMD_STOP;
                        end else begin
                            spd = drive_speed(pos_diff < 0 ? -pos_diff : pos_diff);
                            if (pos_diff < 0) spd = -spd;
                            res.cmd   = CMD_DRIVE;
                            res.speed = 8'(spd);
                        end
                    end
                end
                FUNC_TARGET: wanted_position = tgt;
                FUNC_HOME: begin
                    if (!run_mode) begin
                        run_mode        = 1'b1;
                        wanted_position = home_target;
                    end else begin
                        lens_position = '0;
                    end
                    res.cmd = CMD_STOP;
                end
                FUNC_ENC_REV: if (run_mode) lens_position = lens_position + 16'(steps);
                FUNC_ENC_FWD: if (run_mode) lens_position = lens_position - 16'(steps);
                default: ;
            endcase
            res.position = lens_position;
            res.running  = run_mode;
            pending_results.push_back(res);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(logic [31:0] tdata, logic [1:0] tuser);
            servo_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual cmd %0d data %h",
                         $time, tuser, tdata);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("motor_cmd", int'(want.cmd), int'(tuser));
            check_field("speed", int'($signed(want.speed)), int'($signed(tdata[7:0])));
            check_field("position", int'($signed(want.position)),
                        int'($signed(tdata[23:8])));
            check_field("running", int'(want.running), int'(tdata[24]));
        endfunction

    endclass

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;

    lens_servo_predictor servo_model;
    int  results_seen;
    int  idle_cycles = 0;
    bit  sender_steady;
    bit  receiver_steady;
    int  drift_pct;

    lens_position_servo DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time,
                     servo_model.pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_event(logic [2:0] func, logic [15:0] tgt, logic [7:0] steps);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {8'h00, steps, tgt};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        servo_model.accept_event(func, tgt, steps);
    endtask

    task automatic drain_results();
        int stall;
        bit held;
        held = 1'b0;
        forever begin
            stall = receiver_steady ? 0 : $urandom_range(0, 16);
            if (!held && results_seen >= 400) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            servo_model.compare_result(m_tdata, m_tuser);
            results_seen++;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (servo_model.pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        servo_model.write_reg(idx, data);
    endtask

    task automatic program_servo(int smax, int smin, int tol, logic [15:0] home);
        wait_idle();
        write_reg(CFG_SPEED_MAX, 16'(smax));
        write_reg(CFG_SPEED_MIN, 16'(smin));
        write_reg(CFG_TOLERANCE, 16'(tol));
        write_reg(CFG_HOME_TARGET, home);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_events(int count);
        int sel;
        int offset;
        logic [7:0] steps;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) begin
                sender_steady   = ($urandom_range(0, 3) == 0);
                receiver_steady = ($urandom_range(0, 3) == 0);
                drift_pct       = $urandom_range(20, 80);
            end
            sel    = $urandom_range(0, 99);
            offset = int'($urandom_range(0, 260)) - 130;
            steps  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 30)) : 8'($urandom);
            if (sel < 38) begin
                send_event(FUNC_TICK, 16'($urandom), 8'($urandom));
            end else if (sel < 52) begin
                send_event(FUNC_TARGET, servo_model.lens_position + 16'(offset), 8'($urandom));
            end else if (sel < 59) begin
                send_event(FUNC_TARGET, 16'($urandom), 8'($urandom));
            end else if (sel < 95) begin
                if (int'($urandom_range(0, 99)) < drift_pct) begin
                    send_event(FUNC_ENC_REV, 16'($urandom), steps);
                end else begin
                    send_event(FUNC_ENC_FWD, 16'($urandom), steps);
                end
            end else if (sel < 98) begin
                send_event(FUNC_HOME, 16'($urandom), 8'($urandom));
            end else begin
                send_event(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                           16'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        servo_model     = new();
        results_seen    = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        drift_pct       = 50;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SPEED_MAX;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_TICK;
        m_tready  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            drain_results();
        join_none

        // Homing mode: full speed on a tick, encoder counts and spare codes ignored.
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_ENC_REV, 16'h0000, 8'hFF);
        send_event(FUNC_ENC_FWD, 16'hFFFF, 8'h01);
        send_event(FUNC_TARGET, 16'h7FFF, 8'h00);
        send_event(FUNC_SPARE_FIRST, 16'hFFFF, 8'hFF);
        send_event(FUNC_SPARE_LAST, 16'h8000, 8'h80);
        // First home press enters running mode, a later one zeroes the position.
        send_event(FUNC_HOME, 16'h0000, 8'h00);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_HOME, 16'h0000, 8'h00);
        // Walk through stop, tolerance, minimum speed, ramp and full speed.
        send_event(FUNC_ENC_REV, 16'h0000, 8'hFF);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_TARGET, 16'd255, 8'h00);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_ENC_REV, 16'h0000, 8'd2);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_ENC_REV, 16'h0000, 8'd18);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_ENC_REV, 16'h0000, 8'd80);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_ENC_REV, 16'h0000, 8'd1);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        // Distances at the two ends of the signed 16-bit range.
        send_event(FUNC_HOME, 16'h0000, 8'h00);
        send_event(FUNC_ENC_FWD, 16'h0000, 8'd1);
        send_event(FUNC_TARGET, 16'h7FFF, 8'h00);
        send_event(FUNC_TICK, 16'h0000, 8'h00);
        send_event(FUNC_TARGET, 16'h8000, 8'h00);
        send_event(FUNC_TICK, 16'h0000, 8'h00);

        random_events(150);
        program_servo(127, 0, 0, 16'h8000);
        random_events(200);
        program_servo(0, 127, 255, 16'h7FFF);
        random_events(200);
        for (int p = 0; p < 4; p++) begin
            program_servo($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 12), 16'($urandom));
            random_events(175);
        end

        wait_idle();
        if (servo_model.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lps_pkg.sv
rtl/core/lps_speed_fin.sv
rtl/core/lens_position_servo.sv
dv/tb_lens_position_servo.sv
